// ----- rtl/direction_sum_winner_take_all_core_assert.svh -----
// ----------------------------------------------------------------------------
// direction sum winner-take-all assertion macros
// concurrent checks that compile away when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef DIRECTION_SUM_WINNER_TAKE_ALL_CORE_ASSERT_SVH
`define DIRECTION_SUM_WINNER_TAKE_ALL_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during reset
`define DSWTA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dswta assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define DSWTA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dswta assertion failed");

`else

`define DSWTA_ASSERT_SAME(lbl, ante, cons)
`define DSWTA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/dswta_pkg.sv -----
// ----------------------------------------------------------------------------
// dswta_pkg
// shared types and constants of the direction sum winner-take-all core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dswta_pkg;

    localparam int COST_W   = 32;
    localparam int SUM_W    = 48;
    localparam int SCALED_W = 33;
    localparam int DIRS_W   = 5;
    localparam int DISPS_W  = 8;
    localparam int WEIGHT_W = 17;
    localparam int DIRCNT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [DIRS_W-1:0] MAX_DIRS = 5'd16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIRS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DISPS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DIR_WEIGHT = 2'd2;

    localparam logic [DIRS_W-1:0]   RST_NUM_DIRS       = 5'd4;
    localparam logic [DISPS_W-1:0]  RST_NUM_DISPS      = 8'd64;
    localparam logic [WEIGHT_W-1:0] RST_INV_DIR_WEIGHT = 17'd65536;

    typedef struct packed {
        logic signed [COST_W-1:0] cost_value;
        logic signed [COST_W-1:0] msg_value;
    } dswta_item_t;

    typedef struct packed {
        logic signed [COST_W-1:0] aggregated_cost;
        logic                     label_valid;
        logic [DISPS_W-1:0]       label;
    } dswta_result_t;

    typedef struct packed {
        logic [DIRS_W-1:0]   num_dirs;
        logic [DISPS_W-1:0]  num_disps;
        logic [WEIGHT_W-1:0] inv_dir_weight;
    } dswta_cfg_t;

    // one closed disparity handed from the accumulator to the selector
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    first;
        logic                    last;
        logic [DISPS_W-1:0]      index;
    } dswta_close_t;

endpackage

`default_nettype wire

// ----- rtl/dswta_accum.sv -----
// ----------------------------------------------------------------------------
// dswta_accum
// message scaling stage and per-disparity running sum with direction and
// disparity counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dswta_accum (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dswta_pkg::dswta_cfg_t     cfg,
    input  wire logic                      item_valid,
    output logic                           item_ready,
    input  wire dswta_pkg::dswta_item_t    item,
    output logic                           close_valid,
    input  wire logic                      close_ready,
    output dswta_pkg::dswta_close_t        close
);

    import dswta_pkg::*;

    // scale stage
    logic                       s1_valid_reg;
    logic signed [COST_W-1:0]   s1_cost_reg;
    logic signed [SCALED_W-1:0] s1_scaled_reg;

    // accumulate stage
    logic                      s2_valid_reg;
    dswta_close_t              s2_close_reg;
    logic                      s2_ready;
    logic                      fire;

    logic [DIRCNT_W-1:0]       dir_count_reg, dir_count_next;
    logic [DISPS_W-1:0]        disp_count_reg, disp_count_next;
    logic signed [SUM_W-1:0]   running_sum_reg, running_sum_next;
    logic [DIRS_W-1:0]         nd;
    logic [DISPS_W-1:0]        np;
    logic                      dir_close;
    logic                      disp_last;
    logic signed [SUM_W-1:0]   base;

    function automatic logic signed [COST_W+WEIGHT_W:0] scaled_of(
        input logic signed [COST_W-1:0] msg,
        input logic [WEIGHT_W-1:0]      w
    );
        logic signed [WEIGHT_W:0] ws;
        ws = $signed({1'b0, w});
        return msg * ws;
    endfunction

    always_comb
    begin
        nd = cfg.num_dirs;
        if (cfg.num_dirs == '0)
        begin
            nd = DIRS_W'(1);
        end
        else if (cfg.num_dirs > MAX_DIRS)
        begin
            nd = MAX_DIRS;
        end
        np = (cfg.num_disps == '0) ? DISPS_W'(1) : cfg.num_disps;
    end

    assign item_ready = !s1_valid_reg || s2_ready;
    assign s2_ready   = !s2_valid_reg || close_ready;
    assign fire       = s1_valid_reg && s2_ready;

    // scale stage: signed message times unsigned weight, floor shift by 16
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            s1_cost_reg   <= item.cost_value;
            s1_scaled_reg <= SCALED_W'(scaled_of(item.msg_value, cfg.inv_dir_weight) >>> 16);
        end
    end

    // accumulate stage
    always_comb
    begin
        base             = (dir_count_reg == '0) ? SUM_W'(s1_cost_reg) : running_sum_reg;
        running_sum_next = base + SUM_W'(s1_scaled_reg);
        dir_close        = ({1'b0, dir_count_reg} + DIRS_W'(1)) >= nd;
        disp_last        = ({1'b0, disp_count_reg} + 9'd1) >= {1'b0, np};
        dir_count_next   = dir_close ? '0 : dir_count_reg + DIRCNT_W'(1);
        disp_count_next  = disp_count_reg;
        if (dir_close)
        begin
            disp_count_next = disp_last ? '0 : disp_count_reg + DISPS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg    <= 1'b0;
            dir_count_reg   <= '0;
            disp_count_reg  <= '0;
            running_sum_reg <= '0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= fire && dir_close;
            end
            if (fire)
            begin
                dir_count_reg   <= dir_count_next;
                disp_count_reg  <= disp_count_next;
                running_sum_reg <= dir_close ? '0 : running_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && dir_close)
        begin
            s2_close_reg.sum   <= running_sum_next;
            s2_close_reg.first <= (disp_count_reg == '0);
            s2_close_reg.last  <= disp_last;
            s2_close_reg.index <= disp_count_reg;
        end
    end

    assign close_valid = s2_valid_reg;
    assign close       = s2_close_reg;

endmodule

`default_nettype wire

// ----- rtl/direction_sum_winner_take_all_core.sv -----
// item to result: input, scale, accumulate and output registers in that order
// throughput: one item per cycle unless result_stall holds the output; the
// multiply, accumulate and select stages run concurrently
// reset: counters, running sum, best cost and all valid bits clear; config
// registers return to 4 directions, 64 disparities and unit weight
// ----------------------------------------------------------------------------
// direction_sum_winner_take_all_core
// sums scaled direction messages onto the unary cost of each disparity and
// picks the disparity of least aggregated cost for each pixel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "direction_sum_winner_take_all_core_assert.svh"

module direction_sum_winner_take_all_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // item channel
    input  wire logic                                  item_valid,
    output logic                                       item_stall,
    input  wire dswta_pkg::dswta_item_t                item,
    // result channel
    output logic                                       result_valid,
    input  wire logic                                  result_stall,
    output dswta_pkg::dswta_result_t                   result,
    // configuration write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [dswta_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [dswta_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import dswta_pkg::*;

    // configuration registers
    dswta_cfg_t cfg_reg;

    // input register stage
    logic        s0_valid_reg;
    dswta_item_t s0_item_reg;
    logic        s0_ready;
    logic        acc_ready;

    // closed disparity from the accumulator
    logic         close_valid;
    dswta_close_t close;

    // select and output stage
    logic                     out_valid_reg;
    dswta_result_t            out_reg;
    logic                     out_ready;
    logic                     sel_fire;
    logic signed [COST_W-1:0] best_cost_reg;
    logic [DISPS_W-1:0]       best_index_reg;
    logic signed [COST_W-1:0] agg;
    logic                     take_new;
    logic [DISPS_W-1:0]       label_now;

    // ------------------------------------------------------------------------
    // configuration: always ready, each accepted write is registered
    // unknown index is accepted and dropped
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_dirs       <= RST_NUM_DIRS;
            cfg_reg.num_disps      <= RST_NUM_DISPS;
            cfg_reg.inv_dir_weight <= RST_INV_DIR_WEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NUM_DIRS:       cfg_reg.num_dirs       <= cfg_data[DIRS_W-1:0];
                REG_NUM_DISPS:      cfg_reg.num_disps      <= cfg_data[DISPS_W-1:0];
                REG_INV_DIR_WEIGHT: cfg_reg.inv_dir_weight <= cfg_data[WEIGHT_W-1:0];
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // flow control: each stage loads when empty or when its contents move on,
    // so bubbles are squeezed out even while a result waits on the output
    // ------------------------------------------------------------------------
    assign out_ready  = !out_valid_reg || !result_stall;
    assign s0_ready   = !s0_valid_reg || acc_ready;
    assign item_stall = !s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_ready)
        begin
            s0_valid_reg <= item_valid;
        end
    end

    // payload register, captured on each input transaction
    always_ff @(posedge clk)
    begin
        if (s0_ready && item_valid)
        begin
            s0_item_reg <= item;
        end
    end

    // ------------------------------------------------------------------------
    // scale and accumulate: a registered stage each
    // ------------------------------------------------------------------------
    dswta_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item_valid  (s0_valid_reg),
        .item_ready  (acc_ready),
        .item        (s0_item_reg),
        .close_valid (close_valid),
        .close_ready (out_ready),
        .close       (close)
    );

    // ------------------------------------------------------------------------
    // select: saturate the closed sum, strict less-than keeps the first minimum
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (close.sum[SUM_W-1:COST_W-1] == '0 || close.sum[SUM_W-1:COST_W-1] == '1)
        begin
            agg = close.sum[COST_W-1:0];
        end
        else if (close.sum[SUM_W-1])
        begin
            agg = {1'b1, {(COST_W-1){1'b0}}};
        end
        else
        begin
            agg = {1'b0, {(COST_W-1){1'b1}}};
        end
        take_new  = close.first || (agg < best_cost_reg);
        label_now = take_new ? close.index : best_index_reg;
    end

    assign sel_fire = close_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            best_cost_reg  <= '0;
            best_index_reg <= '0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= close_valid;
            end
            if (sel_fire && take_new)
            begin
                best_cost_reg  <= agg;
                best_index_reg <= close.index;
            end
        end
    end

    // result payload; label reads zero until the pixel closes
    always_ff @(posedge clk)
    begin
        if (sel_fire)
        begin
            out_reg.aggregated_cost <= agg;
            out_reg.label_valid     <= close.last;
            out_reg.label           <= close.last ? label_now : '0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    // a stall on the input only happens with every stage full and output held
    `DSWTA_ASSERT_SAME(a_stall_needs_full, item_stall, s0_valid_reg && out_valid_reg && result_stall)
    // a closed disparity moved into the output stage shows up as a result
    `DSWTA_ASSERT_NEXT(a_close_to_result, sel_fire, result_valid)
    // the first disparity of a pixel always becomes the best so far
    `DSWTA_ASSERT_NEXT(a_first_resets_best, sel_fire && close.first, best_index_reg == '0)

endmodule

`default_nettype wire
